// ===== rtl/ctp_pkg.sv =====
// shared types, constants and codes for the colour table parser
package ctp_pkg;

    localparam int ENTRIES = 35;
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W = $clog2(ENTRIES + 2);
    localparam int TALLY_W = 12;
    localparam int COLOUR_W = 24;
    localparam int PROD_W = 16;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [5:0] LAST_ROW = 6'd33;
    localparam logic [5:0] MID_ROW = 6'd17;
    localparam logic [PROD_W-1:0] RECIP33 = 16'd31776;
    localparam int RECIP_SHIFT = 20;
    localparam logic [PROD_W-1:0] ROUND16 = 16'd15;
    localparam int DIV16_SHIFT = 4;

    localparam logic [COLOUR_W-1:0] DEFAULT_FIRST = 24'hFF9900;

    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_EOT = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    localparam logic RES_PIXEL = 1'b0;
    localparam logic RES_COUNT = 1'b1;

    localparam logic [1:0] SLOT_FIRST = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD = 2'd2;

    localparam logic [1:0] COUNT_ONE = 2'd1;
    localparam logic [1:0] COUNT_TWO = 2'd2;
    localparam logic [1:0] COUNT_THREE = 2'd3;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_INDEX,
        PH_SEP,
        PH_HEX,
        PH_AFTER,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_FETCH,
        RS_BLEND
    } render_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text_byte;
        logic [5:0] entry;
        logic [5:0] row;
    } in_item_t;

    typedef struct packed {
        logic         result_kind;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        logic [TALLY_W-1:0] valid_lines;
    } out_item_t;

    typedef struct packed {
        logic                we;
        logic [1:0]          slot;
        logic [ADDR_W-1:0]   addr;
        logic [COLOUR_W-1:0] colour;
    } commit_t;

    typedef struct packed {
        logic [1:0]          count;
        logic [COLOUR_W-1:0] third;
        logic [COLOUR_W-1:0] second;
        logic [COLOUR_W-1:0] first;
    } entry_t;

endpackage

// ===== rtl/ctp_parser.sv =====
// text parser: line index, hex colours, commits and valid line tally
module ctp_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    input  logic [7:0]                    text_byte,
    input  logic                          restart,
    output ctp_pkg::commit_t              commit,
    output logic [ctp_pkg::TALLY_W-1:0]   tally
);
    import ctp_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [IDX_W-1:0]     index_reg, index_next;
    logic [1:0]           slot_reg, slot_next;
    logic [2:0]           count_reg, count_next;
    logic [COLOUR_W-1:0]  shift_reg, shift_next;
    logic [TALLY_W-1:0]   tally_reg, tally_next;

    logic                 is_digit;
    logic [3:0]           digit;
    logic                 hex_ok;
    logic [3:0]           hex_val;
    phase_t               abandon_phase;
    logic [IDX_W-1:0]     sep_index;
    logic [9:0]           index_grow;
    logic [IDX_W-1:0]     entry_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOKEN;
            index_reg <= '0;
            slot_reg  <= '0;
            count_reg <= '0;
            shift_reg <= '0;
            tally_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            slot_reg  <= slot_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            tally_reg <= tally_next;
        end
    end

    always_comb
    begin
        is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        digit = text_byte[3:0];
        hex_ok = 1'b1;
        hex_val = '0;
        if (is_digit)
        begin
            hex_val = text_byte[3:0];
        end
        else if (((text_byte >= 8'h61) && (text_byte <= 8'h66))
                 || ((text_byte >= 8'h41) && (text_byte <= 8'h46)))
        begin
            hex_val = 4'(text_byte[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            hex_ok = 1'b0;
        end

        if (text_byte == CH_LF)
            abandon_phase = PH_TOKEN;
        else if (text_byte == CH_NUL)
            abandon_phase = PH_DONE;
        else
            abandon_phase = PH_SKIP;

        sep_index = (phase_reg == PH_TOKEN) ? '0 : index_reg;
        index_grow = 10'(index_reg) * 10'd10 + 10'(digit);
        entry_idx = index_reg - IDX_W'(1);

        phase_next = phase_reg;
        index_next = index_reg;
        slot_next = slot_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        tally_next = tally_reg;
        commit = '0;

        if (restart)
        begin
            phase_next = PH_TOKEN;
            index_next = '0;
            slot_next = '0;
            count_next = '0;
            shift_next = '0;
            tally_next = '0;
        end
        else if (byte_valid)
        begin
            unique case (phase_reg)
                PH_TOKEN, PH_INDEX, PH_SEP:
                begin
                    if ((phase_reg == PH_TOKEN) && ((text_byte == CH_HASH)
                        || (text_byte == CH_CR) || (text_byte == CH_LF)
                        || (text_byte == CH_SPACE)))
                    begin
                        phase_next = PH_TOKEN;
                    end
                    else if ((phase_reg != PH_SEP) && is_digit)
                    begin
                        phase_next = PH_INDEX;
                        if (phase_reg == PH_TOKEN)
                            index_next = IDX_W'(digit);
                        else if (index_grow > 10'(ENTRIES + 1))
                            index_next = IDX_W'(ENTRIES + 1);
                        else
                            index_next = IDX_W'(index_grow);
                    end
                    else
                    begin
                        index_next = sep_index;
                        if ((text_byte == CH_SPACE) || (text_byte == CH_EQUAL))
                        begin
                            phase_next = PH_SEP;
                        end
                        else if ((text_byte == CH_HASH) && (sep_index != '0)
                                 && (sep_index <= IDX_W'(ENTRIES)))
                        begin
                            slot_next = SLOT_FIRST;
                            phase_next = PH_HEX;
                            count_next = '0;
                            shift_next = '0;
                        end
                        else
                        begin
                            phase_next = abandon_phase;
                        end
                    end
                end
                PH_HEX:
                begin
                    if (!hex_ok)
                    begin
                        phase_next = abandon_phase;
                    end
                    else
                    begin
                        shift_next = {shift_reg[COLOUR_W-5:0], hex_val};
                        count_next = count_reg + 3'd1;
                        if (count_reg == 3'd5)
                        begin
                            if ((index_reg == '0) || (index_reg > IDX_W'(ENTRIES)))
                            begin
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                commit.we = 1'b1;
                                commit.slot = slot_reg;
                                commit.addr = ADDR_W'(entry_idx);
                                commit.colour = shift_next;
                                if ((slot_reg == SLOT_FIRST) && (tally_reg != TALLY_MAX))
                                    tally_next = tally_reg + TALLY_W'(1);
                                if (slot_reg < SLOT_THIRD)
                                begin
                                    slot_next = slot_reg + 2'd1;
                                    phase_next = PH_AFTER;
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                    end
                end
                PH_AFTER:
                begin
                    if (text_byte == CH_SPACE)
                    begin
                        phase_next = PH_AFTER;
                    end
                    else if (text_byte == CH_HASH)
                    begin
                        phase_next = PH_HEX;
                        count_next = '0;
                        shift_next = '0;
                    end
                    else
                    begin
                        phase_next = abandon_phase;
                    end
                end
                PH_SKIP:
                begin
                    if (text_byte == CH_LF)
                        phase_next = PH_TOKEN;
                    else if (text_byte == CH_NUL)
                        phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign tally = tally_reg;

endmodule

// ===== rtl/colour_table_parser_gradient.sv =====
// top level: parser, colour table memory, gradient render pipeline, result register
// text byte: one per cycle while render idle, no result; end of text: result valid next cycle
// render: table read, blend product, divide stage, result register; input stalled meanwhile,
// so no new render is taken before the last result is registered
// reset clears the parser, tally, render state and table valid bits; every entry then reads
// as one colour FF9900 until a line writes it
module colour_table_parser_gradient (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ctp_pkg::in_item_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output ctp_pkg::out_item_t  result
);
    import ctp_pkg::*;

    entry_t                 mem [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg;
    entry_t                 rd_reg;
    logic                   rd_valid_reg;
    logic [5:0]             y_reg;

    render_state_t          state_reg, state_next;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic [7:0]             lo_reg [3];
    logic [7:0]             lo_next [3];
    logic                   three_reg, three_next;

    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_reg, out_next;

    commit_t                commit;
    logic [TALLY_W-1:0]     tally;
    logic                   accept;
    logic                   out_free;
    logic                   needs_result;
    logic [ADDR_W-1:0]      rd_addr;

    entry_t                 ent;
    logic [COLOUR_W-1:0]    c2, c3;
    logic                   three;
    logic [5:0]             yy;
    logic [7:0]             ch_a, ch_b;
    logic signed [8:0]      diff;
    logic signed [PROD_W-1:0] p;
    logic [PROD_W-1:0]      mag;
    logic [31:0]            recip_prod;
    logic [PROD_W-1:0]      qm;
    logic signed [PROD_W-1:0] q;
    logic [7:0]             v [3];

    ctp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (accept && (item.kind == KIND_TEXT)),
        .text_byte  (item.text_byte),
        .restart    (accept && (item.kind == KIND_EOT)),
        .commit     (commit),
        .tally      (tally)
    );

    assign out_free = !out_valid_reg || !result_stall;
    assign needs_result = (item.kind == KIND_EOT) || (item.kind == KIND_RENDER);
    assign item_stall = (state_reg != RS_IDLE) || (needs_result && !out_free);
    assign accept = item_valid && !item_stall;
    assign rd_addr = (item.entry >= 6'(ENTRIES)) ? ADDR_W'(ENTRIES - 1) : ADDR_W'(item.entry);

    always_ff @(posedge clk)
    begin
        if (commit.we)
        begin
            unique case (commit.slot)
                SLOT_FIRST:
                begin
                    if (!valid_reg[commit.addr])
                    begin
                        mem[commit.addr] <= {COUNT_ONE, COLOUR_W'(0), COLOUR_W'(0),
                                             commit.colour};
                    end
                    else
                    begin
                        mem[commit.addr].first <= commit.colour;
                        mem[commit.addr].count <= COUNT_ONE;
                    end
                end
                SLOT_SECOND:
                begin
                    mem[commit.addr].second <= commit.colour;
                    mem[commit.addr].count <= COUNT_TWO;
                end
                default:
                begin
                    mem[commit.addr].third <= commit.colour;
                    mem[commit.addr].count <= COUNT_THREE;
                end
            endcase
        end
        if (accept && (item.kind == KIND_RENDER))
        begin
            rd_reg <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            y_reg <= (item.row > LAST_ROW) ? LAST_ROW : item.row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            state_reg <= RS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit.we && (commit.slot == SLOT_FIRST))
                valid_reg[commit.addr] <= 1'b1;
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        lo_reg <= lo_next;
        three_reg <= three_next;
        out_reg <= out_next;
    end

    // fetch stage: pick stops and form y times difference per channel
    always_comb
    begin
        ent = rd_valid_reg ? rd_reg : {COUNT_ONE, COLOUR_W'(0), COLOUR_W'(0), DEFAULT_FIRST};
        three = (ent.count == COUNT_THREE);
        c2 = (ent.count >= COUNT_TWO) ? ent.second : ent.first;
        c3 = three ? ent.third : ent.first;
        yy = (three && (y_reg >= MID_ROW)) ? (y_reg - MID_ROW) : y_reg;
        prod_next = prod_reg;
        lo_next = lo_reg;
        three_next = three_reg;
        if (state_reg == RS_FETCH)
        begin
            three_next = three;
            for (int k = 0; k < 3; k++)
            begin
                if (three && (y_reg >= MID_ROW))
                begin
                    ch_a = c2[16 - 8 * k +: 8];
                    ch_b = c3[16 - 8 * k +: 8];
                end
                else
                begin
                    ch_a = ent.first[16 - 8 * k +: 8];
                    ch_b = c2[16 - 8 * k +: 8];
                end
                diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
                prod_next[k] = PROD_W'($signed({1'b0, yy}) * diff);
                lo_next[k] = ch_a;
            end
        end
        else
        begin
            ch_a = '0;
            ch_b = '0;
            diff = '0;
        end
    end

    // blend stage: truncating divide by 16 or 33, then add the lower stop
    always_comb
    begin
        p = '0;
        mag = '0;
        recip_prod = '0;
        qm = '0;
        q = '0;
        for (int k = 0; k < 3; k++)
        begin
            p = prod_reg[k];
            if (three_reg)
            begin
                if (p < 0)
                    q = (p + $signed(ROUND16)) >>> DIV16_SHIFT;
                else
                    q = p >>> DIV16_SHIFT;
            end
            else
            begin
                mag = (p < 0) ? PROD_W'(-p) : PROD_W'(p);
                recip_prod = {16'b0, mag} * {16'b0, RECIP33};
                qm = PROD_W'(recip_prod >> RECIP_SHIFT);
                q = (p < 0) ? -$signed(qm) : $signed(qm);
            end
            v[k] = lo_reg[k] + q[7:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            RS_IDLE:
            begin
                if (accept && (item.kind == KIND_RENDER))
                    state_next = RS_FETCH;
                if (accept && (item.kind == KIND_EOT))
                begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next.result_kind = RES_COUNT;
                    out_next.valid_lines = tally;
                end
            end
            RS_FETCH:
            begin
                state_next = RS_BLEND;
            end
            RS_BLEND:
            begin
                if (out_free)
                begin
                    state_next = RS_IDLE;
                    out_valid_next = 1'b1;
                    out_next.result_kind = RES_PIXEL;
                    out_next.red = v[0];
                    out_next.green = v[1];
                    out_next.blue = v[2];
                    out_next.valid_lines = '0;
                end
            end
            default:
            begin
                state_next = RS_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

endmodule

// ===== tb/sv/colour_table_parser_gradient_tb.sv =====
// testbench for colour_table_parser_gradient: random text tables and renders vs a predictor
module colour_table_parser_gradient_tb;
    import ctp_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_F = "f";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_F = "F";
    localparam int THREE_STOP_DIV = 16;
    localparam int TWO_STOP_DIV = 33;
    localparam int IDLE_PCT = 31;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic clk;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    in_item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    out_item_t result;

    in_item_t pending_items[$];
    bit hold_marks[$];
    bit hold_next = 1'b0;
    out_item_t results_due[$];

    bit item_taken = 1'b0;
    bit calm;
    int items_taken = 0;
    int quiet_cycles = 0;
    int faults = 0;
    int colours_written = 0;
    int pixels_checked = 0;
    int counts_checked = 0;
    int peak_count = 0;

    phase_t parse_state = PH_TOKEN;
    int line_idx = 0;
    logic [1:0] colour_slot = SLOT_FIRST;
    int digits_seen = 0;
    logic [COLOUR_W-1:0] digit_shift = '0;
    logic [TALLY_W-1:0] line_tally = '0;
    logic [COLOUR_W-1:0] first_stop[ENTRIES];
    logic [COLOUR_W-1:0] second_stop[ENTRIES];
    logic [COLOUR_W-1:0] third_stop[ENTRIES];
    logic [1:0] stop_count[ENTRIES];

    colour_table_parser_gradient DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    assign calm = (items_taken >= 600) && (items_taken < 900);

    // predictor

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE) return b - CH_ZERO;
        if (b >= CH_LOWER_A && b <= CH_LOWER_F) return b - CH_LOWER_A + 10;
        if (b >= CH_UPPER_A && b <= CH_UPPER_F) return b - CH_UPPER_A + 10;
        return -1;
    endfunction

    function automatic logic [7:0] shade(input int a, input int b, input int c,
                                         input logic [1:0] n, input int y);
        int v;
        int mid;
        mid = int'(MID_ROW);
        if (n == COUNT_THREE)
        begin
            if (y < mid) v = a + (y * (b - a)) / THREE_STOP_DIV;
            else v = b + ((y - mid) * (c - b)) / THREE_STOP_DIV;
        end
        else
        begin
            v = a + (y * (b - a)) / TWO_STOP_DIV;
        end
        return v[7:0];
    endfunction

    task automatic drop_line(input logic [7:0] b);
        if (b == CH_LF) parse_state = PH_TOKEN;
        else if (b == CH_NUL) parse_state = PH_DONE;
        else parse_state = PH_SKIP;
    endtask

    task automatic open_colour();
        parse_state = PH_HEX;
        digits_seen = 0;
        digit_shift = '0;
    endtask

    task automatic take_separator(input logic [7:0] b);
        if (b == CH_SPACE || b == CH_EQUAL)
        begin
            parse_state = PH_SEP;
        end
        else if (b == CH_HASH && line_idx >= 1 && line_idx <= ENTRIES)
        begin
            colour_slot = SLOT_FIRST;
            open_colour();
        end
        else
        begin
            drop_line(b);
        end
    endtask

    task automatic take_digit(input logic [7:0] b);
        int v;
        int e;
        v = hex_digit(b);
        if (v < 0)
        begin
            drop_line(b);
            return;
        end
        digit_shift = {digit_shift[COLOUR_W-5:0], v[3:0]};
        digits_seen++;
        if (digits_seen < 6) return;
        e = line_idx - 1;
        if (e < 0 || e >= ENTRIES)
        begin
            parse_state = PH_SKIP;
            return;
        end
        colours_written++;
        if (colour_slot == SLOT_FIRST)
        begin
            first_stop[e] = digit_shift;
            stop_count[e] = COUNT_ONE;
            if (line_tally != TALLY_MAX) line_tally++;
        end
        else if (colour_slot == SLOT_SECOND)
        begin
            second_stop[e] = digit_shift;
            stop_count[e] = COUNT_TWO;
        end
        else
        begin
            third_stop[e] = digit_shift;
            stop_count[e] = COUNT_THREE;
        end
        if (colour_slot != SLOT_THIRD)
        begin
            colour_slot++;
            parse_state = PH_AFTER;
        end
        else
        begin
            parse_state = PH_SKIP;
        end
    endtask

    task automatic parse_char(input logic [7:0] b);
        case (parse_state)
            PH_TOKEN:
            begin
                if (b == CH_HASH || b == CH_CR || b == CH_LF || b == CH_SPACE)
                begin
                end
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    line_idx = b - CH_ZERO;
                    parse_state = PH_INDEX;
                end
                else
                begin
                    line_idx = 0;
                    take_separator(b);
                end
            end
            PH_INDEX:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    line_idx = line_idx * 10 + (b - CH_ZERO);
                    if (line_idx > ENTRIES + 1) line_idx = ENTRIES + 1;
                end
                else
                begin
                    take_separator(b);
                end
            end
            PH_SEP: take_separator(b);
            PH_HEX: take_digit(b);
            PH_AFTER:
            begin
                if (b == CH_HASH) open_colour();
                else if (b != CH_SPACE) drop_line(b);
            end
            PH_SKIP:
            begin
                if (b == CH_LF) parse_state = PH_TOKEN;
                else if (b == CH_NUL) parse_state = PH_DONE;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic clear_parser();
        parse_state = PH_TOKEN;
        line_idx = 0;
        colour_slot = SLOT_FIRST;
        digits_seen = 0;
        digit_shift = '0;
        line_tally = '0;
    endtask

    task automatic step_colour_table(input in_item_t it);
        out_item_t r;
        int e;
        int y;
        logic [1:0] n;
        logic [COLOUR_W-1:0] c1;
        logic [COLOUR_W-1:0] c2;
        logic [COLOUR_W-1:0] c3;
        r = '0;
        case (it.kind)
            KIND_TEXT: parse_char(it.text_byte);
            KIND_EOT:
            begin
                r.result_kind = RES_COUNT;
                r.valid_lines = line_tally;
                results_due.push_back(r);
                clear_parser();
            end
            KIND_RENDER:
            begin
                e = (it.entry >= ENTRIES) ? ENTRIES - 1 : it.entry;
                y = (it.row > LAST_ROW) ? LAST_ROW : it.row;
                n = stop_count[e];
                c1 = first_stop[e];
                c2 = (n == COUNT_TWO || n == COUNT_THREE) ? second_stop[e] : c1;
                c3 = (n == COUNT_THREE) ? third_stop[e] : c1;
                r.result_kind = RES_PIXEL;
                r.red = shade(c1[23:16], c2[23:16], c3[23:16], n, y);
                r.green = shade(c1[15:8], c2[15:8], c3[15:8], n, y);
                r.blue = shade(c1[7:0], c2[7:0], c3[7:0], n, y);
                results_due.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (results_due.size() == 0)
        begin
            $error("unexpected result %h", got);
            faults++;
            return;
        end
        want = results_due.pop_front();
        if (want.result_kind == RES_COUNT)
        begin
            counts_checked++;
            if (want.valid_lines > peak_count) peak_count = want.valid_lines;
        end
        else
        begin
            pixels_checked++;
        end
        if (got.result_kind !== want.result_kind)
        begin
            $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
            faults++;
        end
        if (got.red !== want.red)
        begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            faults++;
        end
        if (got.green !== want.green)
        begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            faults++;
        end
        if (got.blue !== want.blue)
        begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            faults++;
        end
        if (got.valid_lines !== want.valid_lines)
        begin
            $error("valid_lines: expected %0d, got %0d", want.valid_lines, got.valid_lines);
            faults++;
        end
    endtask

    // stimulus builders

    task automatic send(input logic [1:0] k, input logic [7:0] b,
                        input logic [5:0] en, input logic [5:0] rw);
        in_item_t it;
        it.kind = k;
        it.text_byte = b;
        it.entry = en;
        it.row = rw;
        pending_items.push_back(it);
        hold_marks.push_back(hold_next);
        hold_next = 1'b0;
    endtask

    task automatic send_char(input logic [7:0] b);
        send(KIND_TEXT, b, 6'($urandom_range(63)), 6'($urandom_range(63)));
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    task automatic send_render(input logic [5:0] en, input logic [5:0] rw);
        send(KIND_RENDER, 8'($urandom_range(255)), en, rw);
    endtask

    task automatic send_eot();
        send(KIND_EOT, 8'($urandom_range(255)), 6'($urandom_range(63)),
             6'($urandom_range(63)));
    endtask

    function automatic logic [7:0] hex_char(input int nib);
        if (nib < 10) return 8'(CH_ZERO + nib);
        return 8'(($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + nib - 10);
    endfunction

    task automatic send_line();
        logic [7:0] chars[$];
        string idx_txt;
        int pick;
        int ncol;
        int k;
        int j;
        pick = $urandom_range(99);
        if (pick < 82) idx_txt = $sformatf("%0d", $urandom_range(ENTRIES, 1));
        else if (pick < 87) idx_txt = "0";
        else if (pick < 93) idx_txt = $sformatf("%0d", $urandom_range(99, ENTRIES + 1));
        else if (pick < 97) idx_txt = $sformatf("%0d", $urandom_range(9999, 100));
        else idx_txt = "";
        if ($urandom_range(9) == 0) idx_txt = {"0", idx_txt};
        repeat ($urandom_range(2))
        begin
            case ($urandom_range(3))
                0: chars.push_back(CH_SPACE);
                1: chars.push_back(CH_HASH);
                2: chars.push_back(CH_CR);
                default: chars.push_back(CH_LF);
            endcase
        end
        for (k = 0; k < idx_txt.len(); k++) chars.push_back(idx_txt[k]);
        repeat ($urandom_range(2)) chars.push_back($urandom_range(1) ? CH_SPACE : CH_EQUAL);
        ncol = $urandom_range(3, 1);
        for (k = 0; k < ncol; k++)
        begin
            if (k > 0) repeat ($urandom_range(2)) chars.push_back(CH_SPACE);
            chars.push_back(CH_HASH);
            for (j = 0; j < 6; j++) chars.push_back(hex_char($urandom_range(15)));
        end
        if ($urandom_range(3) == 0) chars.push_back(CH_SPACE);
        if ($urandom_range(3) == 0) chars.push_back(CH_CR);
        chars.push_back(CH_LF);
        if ($urandom_range(99) < 15)
            chars[$urandom_range(chars.size() - 1)] = 8'($urandom_range(255, 1));
        for (k = 0; k < chars.size(); k++) send_char(chars[k]);
    endtask

    function automatic logic [5:0] pick_entry();
        return 6'(($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(ENTRIES - 1));
    endfunction

    // driver: new transaction or idle at the falling edge

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || item_taken)
        begin
            if (pending_items.size() != 0 && !(hold_marks[0] && results_due.size() != 0)
                && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                item <= pending_items.pop_front();
                void'(hold_marks.pop_front());
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
        result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // monitor and watchdog

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                step_colour_table(item);
                items_taken++;
            end
            if (result_valid && !result_stall) check_result(result);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int k;
        int pick;
        int goal;
        bit mid_hold;
        mid_hold = 1'b0;
        for (k = 0; k < ENTRIES; k++)
        begin
            first_stop[k] = DEFAULT_FIRST;
            second_stop[k] = '0;
            third_stop[k] = '0;
            stop_count[k] = COUNT_ONE;
        end

        send_render(6'd63, 6'd63);
        send(KIND_SPARE, 8'hFF, 6'd63, 6'd63);
        send_text("0#\n");
        send_text("99#\n");
        send_text("=#\n");
        send_eot();
        send_char(CH_NUL);
        send_text("1#");
        send_eot();
        send_render(6'd0, 6'd0);

        hold_next = 1'b1;
        goal = pending_items.size() + RANDOM_ITEMS;
        while (pending_items.size() < goal)
        begin
            if (!mid_hold && pending_items.size() > goal - RANDOM_ITEMS / 2)
            begin
                hold_next = 1'b1;
                mid_hold = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 48)
                send_line();
            else if (pick < 86)
                repeat ($urandom_range(4, 1)) send_render(pick_entry(), 6'($urandom_range(63)));
            else if (pick < 92)
                repeat ($urandom_range(3, 1)) send_char(8'($urandom_range(255, 1)));
            else if (pick < 97)
                send_eot();
            else if (pick < 99)
                send(KIND_SPARE, 8'($urandom_range(255)), 6'($urandom_range(63)),
                     6'($urandom_range(63)));
            else
                send_char(CH_NUL);
        end
        send_eot();
        repeat (8) send_render(pick_entry(), 6'($urandom_range(63)));

        while (pending_items.size() != 0 || item_valid) @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions: %0d colours committed, %0d gradient rows, %0d counts",
                 items_taken, colours_written, pixels_checked, counts_checked);
        $display("highest line count %0d of %0d, %0d mismatches", peak_count, TALLY_MAX, faults);
        if (faults == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
